/* rtl/core/c2p_pkg.sv */
// Shared types, fixed-point constants and the arctangent table for the polar converter.
`timescale 1ns / 1ps

package c2p_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS  = 16;              // fraction bits of the coordinate path
    localparam int MID_W      = 17;              // pre-rotated coordinate, holds +32768
    localparam int ZW         = 34;              // angle accumulator, pi = 2^31
    localparam int ATAN_W     = 30;
    localparam int GAIN_W     = 30;
    localparam int MAX_ITER   = 24;
    localparam int PROD_W     = 64;
    localparam int MAG_SHIFT  = FRAC_BITS + 30;  // drops fraction and gain scale

    localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(1 << 30);   // pi/2

    // Input item
    typedef struct packed {
        logic signed [15:0] x_in;
        logic signed [15:0] y_in;
    } point_t;

    // Result item
    typedef struct packed {
        logic [15:0]        magnitude;
        logic signed [15:0] angle;
    } polar_t;

    // Quarter-turn pre-rotation applied by the front end
    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_POS,
        ROT_NEG
    } prerot_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic signed [MID_W-1:0] x;
        logic signed [MID_W-1:0] y;
        prerot_t                 rot;
        logic                    origin;
    } cls_t;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Number of micro-rotations actually built
    function automatic int iter_count(input int iterations);
        return (iterations < MAX_ITER) ? iterations : MAX_ITER;
    endfunction

    // Span from launch into the back end to result write, used to size the result queue
    function automatic int pipe_latency(input int iterations);
        return iter_count(iterations) + 3;
    endfunction

endpackage

/* rtl/core/c2p_fifo.sv */
// Small register-based queue with full, empty and free-slot count.
`timescale 1ns / 1ps

module c2p_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int FREE_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    output logic [WIDTH-1:0]  rd_data,
    output logic              full,
    output logic              empty,
    output logic [FREE_W-1:0] free
);

    logic [WIDTH-1:0]  mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FREE_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == FREE_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign free    = FREE_W'(DEPTH) - count_reg;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // Pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/c2p_front.sv */
// Front end: sign extension, origin detect and quarter-turn pre-rotation.
`timescale 1ns / 1ps

module c2p_front #(
    parameter int COORD_WIDTH = 16
) (
    input  c2p_pkg::point_t point,
    output c2p_pkg::cls_t   cls
);

    localparam int EFF_W = (COORD_WIDTH > 16) ? 16 : COORD_WIDTH;
    localparam int MW    = c2p_pkg::MID_W;

    logic signed [MW-1:0] xs, ys;

    // Only the low EFF_W bits count
    assign xs = MW'(signed'(point.x_in[EFF_W-1:0]));
    assign ys = MW'(signed'(point.y_in[EFF_W-1:0]));

    // Move left half-plane points into the right half-plane
    always_comb
    begin
        cls.origin = (xs == '0) && (ys == '0);
        cls.x      = xs;
        cls.y      = ys;
        cls.rot    = c2p_pkg::ROT_NONE;
        if (xs[MW-1])
        begin
            if (!ys[MW-1])
            begin
                cls.x   = ys;
                cls.y   = -xs;
                cls.rot = c2p_pkg::ROT_POS;
            end
            else
            begin
                cls.x   = -ys;
                cls.y   = xs;
                cls.rot = c2p_pkg::ROT_NEG;
            end
        end
    end

endmodule

/* rtl/core/c2p_back.sv */
// Back end: unrolled CORDIC vectoring pipeline, gain multiply and rounding.
`timescale 1ns / 1ps

module c2p_back #(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 16,
    parameter int OUT_DEPTH   = 32,
    localparam int FREE_W = $clog2(OUT_DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mid_empty,
    input  c2p_pkg::cls_t     mid_item,
    output logic              mid_pop,
    input  logic [FREE_W-1:0] out_free,
    output logic              res_valid,
    output c2p_pkg::polar_t   res_item
);

    localparam int N      = c2p_pkg::iter_count(ITERATIONS);
    localparam int EFF_W  = (COORD_WIDTH > 16) ? 16 : COORD_WIDTH;
    localparam int FB     = c2p_pkg::FRAC_BITS;
    localparam int DW     = EFF_W + FB + 3;      // coordinate path incl. CORDIC growth
    localparam int UW     = DW - 1;
    localparam int LOW_W  = (UW + 1) / 2;
    localparam int HIGH_W = UW - LOW_W;
    localparam int ZW     = c2p_pkg::ZW;
    localparam int AW     = c2p_pkg::ATAN_W;
    localparam int GW     = c2p_pkg::GAIN_W;
    localparam int PLW    = LOW_W + GW;
    localparam int PHW    = HIGH_W + GW;
    localparam int PW     = c2p_pkg::PROD_W;
    localparam int MS     = c2p_pkg::MAG_SHIFT;
    localparam int MWW    = PW - MS;

    // CORDIC stage registers, index 0 is the launch stage
    logic [N:0]           v_reg;
    logic [N:0]           org_reg;
    logic signed [DW-1:0] x_reg [0:N];
    logic signed [DW-1:0] x_next [0:N];
    logic signed [DW-1:0] y_reg [0:N];
    logic signed [DW-1:0] y_next [0:N];
    logic signed [ZW-1:0] z_reg [0:N];
    logic signed [ZW-1:0] z_next [0:N];

    // Multiply stage
    logic                 mv_reg;
    logic [PLW-1:0]       pl_reg, pl_next;
    logic [PHW-1:0]       ph_reg, ph_next;
    logic signed [15:0]   ang_reg, ang_next;
    logic [UW-1:0]        xc;
    logic signed [ZW-1:0] zr;

    // Rounding stage
    logic                 rv_reg;
    logic [15:0]          mag_reg, mag_next;
    logic signed [15:0]   angf_reg;
    logic [PW-1:0]        sum;
    logic [MWW-1:0]       mw;

    // Credit count: items between launch and result write
    logic [FREE_W-1:0]    inflight_reg, inflight_next;
    logic                 launch;

    assign launch  = !mid_empty && (inflight_reg < out_free);
    assign mid_pop = launch;

    // Launch stage and micro-rotations
    always_comb
    begin
        x_next[0] = DW'(mid_item.x) <<< FB;
        y_next[0] = DW'(mid_item.y) <<< FB;
        unique case (mid_item.rot)
            c2p_pkg::ROT_POS: z_next[0] = c2p_pkg::Z_HALF;
            c2p_pkg::ROT_NEG: z_next[0] = -c2p_pkg::Z_HALF;
            default:          z_next[0] = '0;
        endcase
        for (int i = 0; i < N; i++)
        begin
            // zero residual rotates clockwise
            if (!y_reg[i][DW-1])
            begin
                x_next[i+1] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i]
                    + $signed({{(ZW-AW){1'b0}}, c2p_pkg::atan_entry(5'(i))});
            end
            else
            begin
                x_next[i+1] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i+1] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i+1] = z_reg[i]
                    - $signed({{(ZW-AW){1'b0}}, c2p_pkg::atan_entry(5'(i))});
            end
        end
    end

    // Gain multiply as two partial products, angle rounding
    always_comb
    begin
        xc       = x_reg[N][DW-1] ? '0 : x_reg[N][UW-1:0];
        pl_next  = PLW'(xc[LOW_W-1:0]) * PLW'(c2p_pkg::INV_GAIN);
        ph_next  = PHW'(xc[UW-1:LOW_W]) * PHW'(c2p_pkg::INV_GAIN);
        zr       = z_reg[N] + ZW'(32768);
        ang_next = org_reg[N] ? '0 : signed'(zr[FB+15:FB]);
    end

    // Recombine, round to nearest, saturate
    always_comb
    begin
        sum      = (PW'(ph_reg) << LOW_W) + PW'(pl_reg) + (PW'(1) << (MS - 1));
        mw       = sum[PW-1:MS];
        mag_next = (|mw[MWW-1:16]) ? 16'hFFFF : mw[15:0];
    end

    // Credit update
    always_comb
    begin
        case ({launch, rv_reg})
            2'b10:   inflight_next = inflight_reg + 1'b1;
            2'b01:   inflight_next = inflight_reg - 1'b1;
            default: inflight_next = inflight_reg;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            mv_reg       <= 1'b0;
            rv_reg       <= 1'b0;
            inflight_reg <= '0;
        end
        else
        begin
            v_reg        <= {v_reg[N-1:0], launch};
            mv_reg       <= v_reg[N];
            rv_reg       <= mv_reg;
            inflight_reg <= inflight_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        org_reg <= {org_reg[N-1:0], mid_item.origin};
        for (int i = 0; i <= N; i++)
        begin
            x_reg[i] <= x_next[i];
            y_reg[i] <= y_next[i];
            z_reg[i] <= z_next[i];
        end
        pl_reg   <= pl_next;
        ph_reg   <= ph_next;
        ang_reg  <= ang_next;
        mag_reg  <= mag_next;
        angf_reg <= ang_reg;
    end

    assign res_valid          = rv_reg;
    assign res_item.magnitude = mag_reg;
    assign res_item.angle     = angf_reg;

endmodule

/* rtl/core/cartesian_to_polar_top.sv */
// Top level of the cartesian to polar converter: front end, queues and CORDIC back end.
// Path from input accept to result shown: the launch from the front queue, the
//   unrolled CORDIC stages, the multiply and rounding stages and the write into
//   the result queue.
// Throughput: one item per cycle; the back end launches while its output queue has
//   room for every item still in the pipeline.
// Reset (async, active low) empties both queues and clears all pipeline valid bits.
`timescale 1ns / 1ps

module cartesian_to_polar_top #(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  c2p_pkg::point_t point,
    output logic            empty,
    input  logic            pop,
    output c2p_pkg::polar_t polar
);

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2 ** $clog2(c2p_pkg::pipe_latency(ITERATIONS) + 2);
    localparam int FREE_W    = $clog2(OUT_DEPTH + 1);
    localparam int CLS_W     = $bits(c2p_pkg::cls_t);
    localparam int POL_W     = $bits(c2p_pkg::polar_t);

    c2p_pkg::cls_t   cls;
    c2p_pkg::cls_t   mid_item;
    logic [CLS_W-1:0] mid_data;
    logic            mid_empty;
    logic            mid_pop;
    logic [FREE_W-1:0] out_free;
    logic            res_valid;
    c2p_pkg::polar_t res_item;
    logic [POL_W-1:0] out_data;

    // Classify incoming items
    c2p_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .point(point),
        .cls  (cls)
    );

    // Queue between front and back
    c2p_fifo #(
        .WIDTH(CLS_W),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push && !full),
        .wr_data(cls),
        .rd_en  (mid_pop),
        .rd_data(mid_data),
        .full   (full),
        .empty  (mid_empty),
        .free   ()
    );

    assign mid_item = c2p_pkg::cls_t'(mid_data);

    // CORDIC pipeline
    c2p_back #(
        .ITERATIONS (ITERATIONS),
        .COORD_WIDTH(COORD_WIDTH),
        .OUT_DEPTH  (OUT_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mid_empty(mid_empty),
        .mid_item (mid_item),
        .mid_pop  (mid_pop),
        .out_free (out_free),
        .res_valid(res_valid),
        .res_item (res_item)
    );

    // Result queue, sized to absorb a full pipeline
    c2p_fifo #(
        .WIDTH(POL_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_valid),
        .wr_data(res_item),
        .rd_en  (pop && !empty),
        .rd_data(out_data),
        .full   (),
        .empty  (empty),
        .free   (out_free)
    );

    assign polar = c2p_pkg::polar_t'(out_data);

endmodule

/* dv/tb_cartesian_to_polar_top.sv */
// Self-checking testbench for the cartesian to polar converter top level.
`timescale 1ns / 1ps

module tb_cartesian_to_polar_top;

    localparam int CORDIC_STAGES = 16;
    localparam int COORD_W       = 16;
    localparam int MAX_ROT       = 24;
    localparam int FRAC          = 16;
    localparam int LATENCY       = CORDIC_STAGES + 4;
    localparam int IDLE_LIMIT    = 5000;
    localparam int MAX_REPORTS   = 10;
    localparam logic [63:0] GAIN_INV = 64'd652032874;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            push;
    logic            full;
    c2p_pkg::point_t point;
    logic            empty;
    logic            pop;
    c2p_pkg::polar_t polar;

    c2p_pkg::polar_t pending_polar[$];
    int     failures      = 0;
    int     idle_cycles   = 0;
    int     send_idle_pct = 30;
    int     recv_idle_pct = 30;

    cartesian_to_polar_top #(
        .ITERATIONS (CORDIC_STAGES),
        .COORD_WIDTH(COORD_W)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .full (full),
        .point(point),
        .empty(empty),
        .pop  (pop),
        .polar(polar)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // atan(2^-i) in units of pi/2^31
    function automatic longint atan_step(input int i);
        case (i)
            0:       return 536870912;
            1:       return 316933406;
            2:       return 167458907;
            3:       return 85004756;
            4:       return 42667331;
            5:       return 21354465;
            6:       return 10679838;
            7:       return 5340245;
            8:       return 2670163;
            9:       return 1335087;
            10:      return 667544;
            11:      return 333772;
            12:      return 166886;
            13:      return 83443;
            14:      return 41722;
            15:      return 20861;
            16:      return 10430;
            17:      return 5215;
            18:      return 2608;
            19:      return 1304;
            20:      return 652;
            21:      return 326;
            22:      return 163;
            23:      return 81;
            default: return 0;
        endcase
    endfunction

    // Expected magnitude and angle of one point, CORDIC vectoring in fixed point
    function automatic c2p_pkg::polar_t polar_of(input c2p_pkg::point_t p);
        longint          x, y, t, z, cx, cy, dx, dy, a;
        logic [63:0]     ux, prod, mag;
        c2p_pkg::polar_t r;
        int              w;
        w = (COORD_W > 16) ? 16 : COORD_W;
        x = longint'(p.x_in);
        y = longint'(p.y_in);
        x = (x <<< (64 - w)) >>> (64 - w);
        y = (y <<< (64 - w)) >>> (64 - w);
        z = 0;
        r = '0;
        if (x == 0 && y == 0)
            return r;
        // quarter turn into the right half-plane
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = 64'sd1 <<< 30;
            end
            else
            begin
                x = -y;
                y = t;
                z = -(64'sd1 <<< 30);
            end
        end
        cx = x <<< FRAC;
        cy = y <<< FRAC;
        // micro-rotations; y == 0 takes the clockwise branch
        for (int i = 0; i < CORDIC_STAGES && i < MAX_ROT; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0)
            begin
                cx += dx;
                cy -= dy;
                z  += atan_step(i);
            end
            else
            begin
                cx -= dx;
                cy += dy;
                z  -= atan_step(i);
            end
        end
        if (cx < 0)
            cx = 0;
        ux   = cx;
        prod = ux * GAIN_INV;
        mag  = (prod + (64'd1 << (FRAC + 29))) >> (FRAC + 30);
        if (mag > 64'hFFFF)
            mag = 64'hFFFF;
        // round to binary angle; +pi wraps to -pi
        a = (z + 64'sd32768) >>> 16;
        r.magnitude = mag[15:0];
        r.angle     = a[15:0];
        return r;
    endfunction

    function automatic c2p_pkg::point_t mk_point(input int x, input int y);
        c2p_pkg::point_t p;
        p.x_in = 16'(x);
        p.y_in = 16'(y);
        return p;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Send one item; returns at the falling edge after it is accepted
    task automatic send_point(input c2p_pkg::point_t p);
        int gap;
        gap = 0;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            gap = gap_len();
        if (gap > 0)
        begin
            push  <= 1'b0;
            point <= c2p_pkg::point_t'($urandom);
            repeat (gap) @(negedge clk);
        end
        push  <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // Result side: pop with random stalls
    initial
    begin
        int stall;
        stall = 0;
        pop   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
            begin
                pop   <= 1'b0;
                stall = gap_len() - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    // Monitor: predict on accepted inputs, compare accepted results
    always @(posedge clk)
    begin
        c2p_pkg::polar_t want;
        if (rst_n)
        begin
            if (push && !full)
                pending_polar.push_back(polar_of(point));
            if (pop && !empty)
            begin
                if (pending_polar.size() == 0)
                    note_failure($sformatf("unexpected result mag=%0d ang=%0d",
                                           polar.magnitude, polar.angle));
                else
                begin
                    want = pending_polar.pop_front();
                    if (polar.magnitude !== want.magnitude || polar.angle !== want.angle)
                        note_failure($sformatf("mag exp=%0d got=%0d, ang exp=%0d got=%0d",
                                               want.magnitude, polar.magnitude,
                                               want.angle, polar.angle));
                end
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without progress
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Axis extremes, diagonals, origin, zero residual and the wrap at +pi
    task automatic test_directed_points();
        send_point(mk_point(0, 0));
        send_point(mk_point(32767, 0));
        send_point(mk_point(-32768, 0));
        send_point(mk_point(0, 32767));
        send_point(mk_point(0, -32768));
        send_point(mk_point(-32768, -32768));
        send_point(mk_point(32767, 32767));
        send_point(mk_point(-32768, 32767));
        send_point(mk_point(32767, -32768));
        send_point(mk_point(-32768, 1));
        send_point(mk_point(-32768, -1));
        send_point(mk_point(-5, 0));
        send_point(mk_point(1, 0));
        send_point(mk_point(-1, 0));
        send_point(mk_point(0, 1));
        send_point(mk_point(0, -1));
        send_point(mk_point(1, 1));
        send_point(mk_point(-1, 1));
        send_point(mk_point(-1, -1));
        send_point(mk_point(1, -1));
        send_point(mk_point(16'h5555, 16'hAAAA));
        send_point(mk_point(16'hAAAA, 16'h5555));
        send_point(mk_point(0, 0));
    endtask

    // Full-range points, idle mix changed every hundred items
    task automatic test_random_plane(input int count);
        int pcts[3];
        pcts = '{0, 20, 60};
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 0)
            begin
                send_idle_pct = pcts[$urandom_range(2)];
                recv_idle_pct = pcts[$urandom_range(2)];
            end
            send_point(c2p_pkg::point_t'($urandom));
        end
        send_idle_pct = 30;
        recv_idle_pct = 30;
    endtask

    // Small points, axes and the negative x axis near the wrap
    task automatic test_near_origin(input int count);
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(3);
            case (kind)
                0: send_point(mk_point($urandom_range(16) - 8, $urandom_range(16) - 8));
                1: send_point(mk_point(int'($urandom_range(65535)) - 32768, 0));
                2: send_point(mk_point(0, int'($urandom_range(65535)) - 32768));
                default: send_point(mk_point(-int'($urandom_range(32768, 1)),
                                             $urandom_range(4) - 2));
            endcase
        end
    endtask

    // Back-to-back items with the result side always ready
    task automatic test_full_rate(input int count);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < count; n++)
            send_point(c2p_pkg::point_t'($urandom));
        send_idle_pct = 30;
        recv_idle_pct = 30;
    endtask

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        push  = 1'b0;
        point = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_points();
        test_random_plane(1000);
        test_near_origin(500);
        test_full_rate(400);
        push <= 1'b0;

        // drain
        while (pending_polar.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (failures == 0 && pending_polar.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
